@@ rtl/dmxr_pkg.sv @@
package dmxr_pkg;

  localparam int SLOTS     = 512;
  localparam int CNT_W     = 10;
  localparam int BANK_W    = 9;
  localparam int STORE_W   = BANK_W + 1;
  localparam int TIMER_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIMER_W-1:0] TIMEOUT_RST = TIMER_W'(1000);
  localparam logic [7:0]         START_CODE  = 8'h00;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ACK  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]        operation;
    logic              line_error;
    logic [7:0]        rx_byte;
    logic [BANK_W-1:0] slot_addr;
  } in_item_t;

  typedef struct packed {
    logic       frame_ready;
    logic       signal_present;
    logic [7:0] slot_data;
  } out_item_t;

  typedef struct packed {
    logic               wr;
    logic               rd_ok;
    logic [STORE_W-1:0] addr;
    logic [7:0]         wdata;
    logic               frame_ready;
    logic               signal_present;
  } cmd_t;

endpackage

@@ rtl/dmxr_front.sv @@
module dmxr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dmxr_pkg::in_item_t                  in_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dmxr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmxr_pkg::TIMER_W-1:0]        cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output dmxr_pkg::cmd_t                      q_cmd
);

  logic                          enable_r, enable_nxt;
  logic [dmxr_pkg::TIMER_W-1:0]  timeout_r, timeout_nxt;
  logic [dmxr_pkg::CNT_W-1:0]    slot_cnt_r, slot_cnt_nxt;
  logic                          ready_r, ready_nxt;
  logic [dmxr_pkg::TIMER_W-1:0]  timer_r, timer_nxt;
  logic                          bank_r, bank_nxt;
  logic                          accept;
  logic                          cfg_wr;
  logic [dmxr_pkg::CNT_W-1:0]    pos;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !q_full;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign pos       = slot_cnt_r - dmxr_pkg::CNT_W'(1);

  always_comb begin
    enable_nxt   = enable_r;
    timeout_nxt  = timeout_r;
    slot_cnt_nxt = slot_cnt_r;
    ready_nxt    = ready_r;
    timer_nxt    = timer_r;
    bank_nxt     = bank_r;
    q_cmd.wr     = 1'b0;
    q_cmd.rd_ok  = 1'b0;
    q_cmd.addr   = {bank_r, in_item.slot_addr};
    q_cmd.wdata  = in_item.rx_byte;
    if (cfg_wr) begin
      unique case (cfg_index)
        dmxr_pkg::CFG_ENABLE: begin
          enable_nxt   = cfg_data[0];
          ready_nxt    = 1'b0;
          slot_cnt_nxt = dmxr_pkg::CNT_W'(dmxr_pkg::SLOTS);
          timer_nxt    = timeout_r;
        end
        dmxr_pkg::CFG_TIMEOUT: begin
          timeout_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      unique case (in_item.operation)
        dmxr_pkg::OP_BYTE: begin
          if (enable_r) begin
            if (in_item.line_error) begin
              slot_cnt_nxt = '0;
            end else if (slot_cnt_r == '0) begin
              if (in_item.rx_byte == dmxr_pkg::START_CODE) begin
                timer_nxt = timeout_r;
                if (!ready_r) begin
                  bank_nxt  = ~bank_r;
                  ready_nxt = 1'b1;
                end
                slot_cnt_nxt = dmxr_pkg::CNT_W'(1);
              end else begin
                slot_cnt_nxt = dmxr_pkg::CNT_W'(dmxr_pkg::SLOTS);
              end
            end else if (slot_cnt_r < dmxr_pkg::CNT_W'(dmxr_pkg::SLOTS)) begin
              q_cmd.wr     = 1'b1;
              q_cmd.addr   = {~bank_r, pos[dmxr_pkg::BANK_W-1:0]};
              slot_cnt_nxt = slot_cnt_r + dmxr_pkg::CNT_W'(1);
            end
          end
        end
        dmxr_pkg::OP_TICK: begin
          if (timer_r != '0) begin
            timer_nxt = timer_r - dmxr_pkg::TIMER_W'(1);
          end
        end
        dmxr_pkg::OP_ACK: begin
          ready_nxt = 1'b0;
        end
        dmxr_pkg::OP_READ: begin
          q_cmd.rd_ok = {1'b0, in_item.slot_addr} < dmxr_pkg::CNT_W'(dmxr_pkg::SLOTS - 1);
        end
        default: begin
        end
      endcase
    end
    q_cmd.frame_ready    = ready_nxt;
    q_cmd.signal_present = timer_nxt != '0;
  end

  assign q_push = accept && !cfg_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      timeout_r  <= dmxr_pkg::TIMEOUT_RST;
      slot_cnt_r <= dmxr_pkg::CNT_W'(dmxr_pkg::SLOTS);
      ready_r    <= 1'b0;
      timer_r    <= '0;
      bank_r     <= 1'b0;
    end else begin
      enable_r   <= enable_nxt;
      timeout_r  <= timeout_nxt;
      slot_cnt_r <= slot_cnt_nxt;
      ready_r    <= ready_nxt;
      timer_r    <= timer_nxt;
      bank_r     <= bank_nxt;
    end
  end

endmodule

@@ rtl/dmxr_queue.sv @@
module dmxr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dmxr_pkg::cmd_t din,
  input  logic           pop,
  output dmxr_pkg::cmd_t dout,
  output logic           empty,
  output logic           full
);

  dmxr_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign empty = cnt_r == 2'd0;
  assign full  = cnt_r == 2'd2;
  assign dout  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/dmxr_back.sv @@
module dmxr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  dmxr_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output dmxr_pkg::out_item_t out_item
);

  logic [7:0] store_r [2**dmxr_pkg::STORE_W];
  logic [7:0] rd_data_r;
  logic       rd_ok_r;
  logic       ready_r;
  logic       present_r;
  logic       out_valid_r, out_valid_nxt;

  assign q_pop         = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = q_pop ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.wr) begin
      store_r[q_cmd.addr] <= q_cmd.wdata;
    end
    if (q_pop) begin
      rd_data_r <= store_r[q_cmd.addr];
      rd_ok_r   <= q_cmd.rd_ok;
      ready_r   <= q_cmd.frame_ready;
      present_r <= q_cmd.signal_present;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_item.frame_ready    = ready_r;
  assign out_item.signal_present = present_r;
  assign out_item.slot_data      = rd_ok_r ? rd_data_r : 8'h00;

endmodule

@@ rtl/dmx512_frame_receiver_top.sv @@
// DMX512 frame receiver with double-banked slot storage.
// Input channel (in_valid / in_stall / in_item): one operation per transfer:
// received byte with line-error flag, timer tick, frame acknowledge, or a
// read of one front-bank slot. Every transfer yields exactly one result on
// the output channel (out_valid / out_stall / out_item), in order.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0
// is enable, index 1 the silence timeout; cfg_ready is always high. Write
// only while the block is idle. Other indexes are ignored.
// A result is registered in a queue entry, then in the back's registers.
// Throughput is one item per cycle while out_stall is low: the front updates
// frame state in the accept cycle; the back does one slot-store access per
// cycle (one write or one read). A two-entry queue separates front and back;
// in_stall rises only when it is full, so out_stall backs up into in_stall
// once two items queue behind a held result. Reset: enable 0, timeout 1000,
// slot counter waiting for a break, frame ready and silence timer cleared,
// front bank 0. Slot store is not cleared; no setup sweep is needed.
module dmx512_frame_receiver_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dmxr_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dmxr_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dmxr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmxr_pkg::TIMER_W-1:0]    cfg_data
);

  dmxr_pkg::cmd_t push_cmd;
  dmxr_pkg::cmd_t pop_cmd;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;

  dmxr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  dmxr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_cmd),
    .pop   (pop),
    .dout  (pop_cmd),
    .empty (q_empty),
    .full  (q_full)
  );

  dmxr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
